/* hdl/assert_macros.svh */
// Assertion macros used by the checker file lcbse_checker.
// Depends on nothing; take in with `include before the module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* hdl/lcbse_pkg.sv */
// Types, constants and command codes of the LED chain bit-slot encoder.
// No dependencies.
package lcbse_pkg;

  localparam int LED_TOTAL_DEF   = 16;
  localparam int RESET_SLOTS_DEF = 64;
  localparam int BITS_PER_LED    = 24;
  localparam int BIT_W           = 5;
  localparam int ADDR_W          = 3;
  localparam int DATA_W          = 32;

  localparam logic [15:0] DUTY_ONE_RST  = 16'd68;
  localparam logic [15:0] DUTY_ZERO_RST = 16'd34;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_SHOW  = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_DUTY_ONE  = 1'b0,
    REG_DUTY_ZERO = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] led_index;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } req_t;

  typedef struct packed {
    logic [15:0] duty;
    logic        slot_valid;
    logic        frame_last;
    logic        rejected;
  } res_t;

  typedef struct packed {
    logic [15:0] duty_one;
    logic [15:0] duty_zero;
  } cfg_t;

  typedef struct packed {
    logic        wr_en;
    logic        clr;
    logic [7:0]  addr;
    logic [23:0] colour;
  } store_wr_t;

endpackage

/* hdl/led_chain_bit_slot_encoder.sv */
// Top level of the LED chain bit-slot encoder.
// A request is held in the request register; its result goes to the result register.
// Throughput: one request per cycle while the result is not stalled; the colour store is read ahead.
// Reset: synchronous; clears frame state, store valid bits, and sets the
// duty registers to 68 and 34. Depends on lcbse_pkg, lcbse_regs,
// lcbse_store and lcbse_core.
module led_chain_bit_slot_encoder #(
  parameter int LED_TOTAL   = lcbse_pkg::LED_TOTAL_DEF,
  parameter int RESET_SLOTS = lcbse_pkg::RESET_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  lcbse_pkg::req_t              req_data,
  output logic                         res_valid,
  input  logic                         res_stall,
  output lcbse_pkg::res_t              res_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcbse_pkg::ADDR_W-1:0] paddr,
  input  logic [lcbse_pkg::DATA_W-1:0] pwdata,
  output logic [lcbse_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);
  import lcbse_pkg::*;

  localparam int IDX_W = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;

  cfg_t             cfg;
  store_wr_t        store_wr;
  logic [IDX_W-1:0] rd_addr;
  logic [23:0]      rd_colour;

  lcbse_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lcbse_store #(
    .LED_TOTAL (LED_TOTAL),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .wr        (store_wr),
    .rd_addr   (rd_addr),
    .rd_colour (rd_colour)
  );

  lcbse_core #(
    .LED_TOTAL   (LED_TOTAL),
    .RESET_SLOTS (RESET_SLOTS),
    .IDX_W       (IDX_W)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg       (cfg),
    .store_wr  (store_wr),
    .rd_addr   (rd_addr),
    .rd_colour (rd_colour)
  );

endmodule

/* hdl/lcbse_regs.sv */
// Configuration registers (duty values) behind the APB-style port.
// Depends on lcbse_pkg.
module lcbse_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcbse_pkg::ADDR_W-1:0] paddr,
  input  logic [lcbse_pkg::DATA_W-1:0] pwdata,
  output logic [lcbse_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output lcbse_pkg::cfg_t             cfg
);
  import lcbse_pkg::*;

  logic wr;
  reg_e sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = reg_e'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_one  <= DUTY_ONE_RST;
      cfg.duty_zero <= DUTY_ZERO_RST;
    end else if (wr) begin
      unique case (sel)
        REG_DUTY_ONE:  cfg.duty_one  <= pwdata[15:0];
        REG_DUTY_ZERO: cfg.duty_zero <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_DUTY_ONE:  prdata = {16'd0, cfg.duty_one};
      REG_DUTY_ZERO: prdata = {16'd0, cfg.duty_zero};
      default:       prdata = '0;
    endcase
  end

endmodule

/* hdl/lcbse_store.sv */
// Colour store: one 24-bit colour per LED with per-entry valid bits and a
// registered read port. Depends on lcbse_pkg.
module lcbse_store #(
  parameter int LED_TOTAL = lcbse_pkg::LED_TOTAL_DEF,
  parameter int IDX_W     = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lcbse_pkg::store_wr_t wr,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [23:0]          rd_colour
);
  import lcbse_pkg::*;

  logic [23:0]          mem [LED_TOTAL];
  logic [LED_TOTAL-1:0] valid;
  logic [23:0]          rd_q;
  logic                 rd_ok;
  logic [IDX_W-1:0]     wr_addr;

  assign wr_addr = wr.addr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.clr) begin
      valid <= '0;
    end else if (wr.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      mem[wr_addr] <= wr.colour;
    end
  end

  always_ff @(posedge clk) begin
    rd_q  <= mem[rd_addr];
    rd_ok <= valid[rd_addr];
  end

  assign rd_colour = rd_ok ? rd_q : 24'd0;

endmodule

/* hdl/lcbse_core.sv */
// Request register, frame sequencer and result register.
// Depends on lcbse_pkg; drives the colour store write and read ports.
module lcbse_core #(
  parameter int LED_TOTAL   = lcbse_pkg::LED_TOTAL_DEF,
  parameter int RESET_SLOTS = lcbse_pkg::RESET_SLOTS_DEF,
  parameter int IDX_W       = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  lcbse_pkg::req_t      req_data,
  output logic                 res_valid,
  input  logic                 res_stall,
  output lcbse_pkg::res_t      res_data,
  input  lcbse_pkg::cfg_t      cfg,
  output lcbse_pkg::store_wr_t store_wr,
  output logic [IDX_W-1:0]     rd_addr,
  input  logic [23:0]          rd_colour
);
  import lcbse_pkg::*;

  localparam int LED_W   = $clog2(LED_TOTAL + 1);
  localparam int PAD_W   = (RESET_SLOTS > 1) ? $clog2(RESET_SLOTS) : 1;
  localparam bit HAS_PAD = (RESET_SLOTS > 0);
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BITS_PER_LED - 1);

  logic             q_valid;
  req_t             q_data;
  logic             adv;
  logic             fire;
  cmd_e             cmd;

  logic             active, active_next;
  logic [LED_W-1:0] led, led_next;
  logic [BIT_W-1:0] bit_pos, bit_pos_next;
  logic [PAD_W-1:0] pad, pad_next;
  res_t             res_next;
  logic             in_data;
  logic             is_last;
  logic [BIT_W-1:0] sel;

  assign adv       = !res_valid || !res_stall;
  assign fire      = q_valid && adv;
  assign req_stall = q_valid && !adv;
  assign cmd       = cmd_e'(q_data.command);

  assign in_data = (led < LED_W'(LED_TOTAL));
  assign sel     = {bit_pos[4:3], ~bit_pos[2:0]};

  always_comb begin
    if (HAS_PAD) begin
      is_last = !in_data && (pad == PAD_W'(RESET_SLOTS - 1));
    end else begin
      is_last = (led == LED_W'(LED_TOTAL - 1)) && (bit_pos == LAST_BIT);
    end
  end

  always_comb begin
    active_next  = active;
    led_next     = led;
    bit_pos_next = bit_pos;
    pad_next     = pad;
    res_next     = '0;
    store_wr     = '0;
    if (fire) begin
      unique case (cmd)
        CMD_TICK: begin
          if (active) begin
            res_next.slot_valid = 1'b1;
            if (in_data) begin
              res_next.duty = rd_colour[sel] ? cfg.duty_one : cfg.duty_zero;
            end
            if (is_last) begin
              res_next.frame_last = 1'b1;
              active_next         = 1'b0;
              led_next            = '0;
              bit_pos_next        = '0;
              pad_next            = '0;
            end else if (in_data) begin
              if (bit_pos == LAST_BIT) begin
                bit_pos_next = '0;
                led_next     = led + LED_W'(1);
              end else begin
                bit_pos_next = bit_pos + BIT_W'(1);
              end
            end else begin
              pad_next = pad + PAD_W'(1);
            end
          end
        end
        CMD_SET: begin
          if (active) begin
            res_next.rejected = 1'b1;
          end else if ({1'b0, q_data.led_index} < 9'(LED_TOTAL)) begin
            store_wr.wr_en  = 1'b1;
            store_wr.addr   = q_data.led_index;
            store_wr.colour = {q_data.red_level, q_data.green_level,
                               q_data.blue_level};
          end
        end
        CMD_CLEAR: begin
          if (active) begin
            res_next.rejected = 1'b1;
          end else begin
            store_wr.clr = 1'b1;
          end
        end
        CMD_SHOW: begin
          active_next  = 1'b1;
          led_next     = '0;
          bit_pos_next = '0;
          pad_next     = '0;
        end
        default: ;
      endcase
    end
  end

  // prefetch the colour of the LED the next request will use
  assign rd_addr = (led_next < LED_W'(LED_TOTAL)) ? led_next[IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid   <= 1'b0;
      res_valid <= 1'b0;
      active    <= 1'b0;
      led       <= '0;
      bit_pos   <= '0;
      pad       <= '0;
    end else begin
      if (!req_stall) begin
        q_valid <= req_valid;
      end
      if (fire) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      active  <= active_next;
      led     <= led_next;
      bit_pos <= bit_pos_next;
      pad     <= pad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      q_data <= req_data;
    end
    if (fire) begin
      res_data <= res_next;
    end
  end

endmodule

/* hdl/lcbse_checker.sv */
// Port-level checks of the LED chain bit-slot encoder, bound to the top.
// Depends on lcbse_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcbse_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_stall,
  input lcbse_pkg::req_t              req_data,
  input logic                         res_valid,
  input logic                         res_stall,
  input lcbse_pkg::res_t              res_data,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [lcbse_pkg::ADDR_W-1:0] paddr,
  input logic [lcbse_pkg::DATA_W-1:0] pwdata,
  input logic [lcbse_pkg::DATA_W-1:0] prdata,
  input logic                         pready
);
  import lcbse_pkg::*;

  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !res_valid, "result valid after reset")
  `ASSERT_CLK(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid && $stable(res_data), "stalled result changed")
  `ASSERT_CLK(a_slot_or_reject, clk, rst, res_valid |-> !(res_data.slot_valid && res_data.rejected), "slot and reject together")
  `ASSERT_CLK(a_last_is_slot, clk, rst, res_valid && res_data.frame_last |-> res_data.slot_valid, "frame end without slot")
  `ASSERT_CLK(a_duty_is_slot, clk, rst, res_valid && (res_data.duty != 16'd0) |-> res_data.slot_valid, "duty outside a slot")

endmodule

bind led_chain_bit_slot_encoder lcbse_checker u_lcbse_checker (.*);
